// ----- rtl/plcf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcf_pkg
// Shared types and constants of the priority LED color frame block.
// ----------------------------------------------------------------------------
package plcf_pkg;

   localparam int LED_COUNT   = 16;
   localparam int LED_IDX_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int SLOT_DEPTH  = 2 * LED_COUNT;
   localparam int SLOT_ADDR_W = LED_IDX_W + 1;

   localparam int CHAN_W      = 8;
   localparam int LEVEL_W     = 6;
   localparam int MODE_W      = 8;
   localparam int SUM_W       = 10;
   localparam int NUM_W       = 14;
   localparam int TRIAL_W     = 16;
   localparam int CHAN_COUNT  = 3;
   localparam int QUO_STEPS   = 6;
   localparam int STEP_W      = 3;

   localparam logic [LEVEL_W-1:0] BRIGHT_HIGH = 6'd50;
   localparam logic [LEVEL_W-1:0] BRIGHT_LOW  = 6'd30;

   localparam logic [7:0] CSR_BRIGHT = 8'd0;
   localparam logic [7:0] CSR_BLINK  = 8'd1;

   localparam logic [MODE_W-1:0] BRIGHT_RESET = 8'd1;
   localparam logic [MODE_W-1:0] BLINK_RESET  = 8'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_TICK_RD,
      ST_TICK_OUT,
      ST_CLEAR_OUT,
      ST_ERR_OUT
   } state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] blue;
      logic [MODE_W-1:0]  mode;
   } slot_entry_type;

   // Channel order inside the scaler: red, green, blue.
   typedef logic [CHAN_COUNT-1:0][CHAN_W-1:0]  chan_vec_type;
   typedef logic [CHAN_COUNT-1:0][LEVEL_W-1:0] level_vec_type;

endpackage
`default_nettype wire

// ----- rtl/plcf_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plcf_scale
// Color scaler: value * brightness / channel sum for three channels, a
// multiply on start followed by a shared six-step restoring divide.
// ----------------------------------------------------------------------------
module plcf_scale (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   bright_high,
   input  wire plcf_pkg::chan_vec_type chan,
   output logic                        done,
   output plcf_pkg::level_vec_type     level
);
   import plcf_pkg::*;

   logic [SUM_W-1:0]                  sum_ff, sum_in;
   logic [CHAN_COUNT-1:0][NUM_W-1:0]  rem_ff, rem_in;
   logic [CHAN_COUNT-1:0][LEVEL_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [LEVEL_W-1:0]                bright;
   logic [TRIAL_W-1:0]                trial;

   assign bright = bright_high ? BRIGHT_HIGH : BRIGHT_LOW;
   assign trial  = TRIAL_W'(sum_ff) << step_ff;

   always_comb begin
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sum_in  = SUM_W'(chan[0]) + SUM_W'(chan[1]) + SUM_W'(chan[2]);
         for (int c = 0; c < CHAN_COUNT; c++) begin
            rem_in[c] = NUM_W'(chan[c]) * NUM_W'(bright);
            quo_in[c] = '0;
         end
         step_in = STEP_W'(QUO_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The quotient never exceeds fifty, so six bits always suffice.
         for (int c = 0; c < CHAN_COUNT; c++) begin
            if (TRIAL_W'(rem_ff[c]) >= trial) begin
               rem_in[c] = NUM_W'(TRIAL_W'(rem_ff[c]) - trial);
               quo_in[c] = quo_ff[c] | (LEVEL_W'(1) << step_ff);
            end
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done  = done_ff;
   assign level = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/priority_led_color_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_led_color_frame
// Per-LED color store with two priority slots, color scaling and frame output.
// ----------------------------------------------------------------------------
// Each LED holds two slots of scaled color and mode in one synchronous memory
// addressed by LED and slot; per-entry valid bits make unwritten or cleared
// entries read as black, so there is no clearing pass after reset. A write of
// a nonzero color holds off the next word until it is done: accept and
// multiply, six restoring divide steps shared by the three channels, and the
// memory write. A black write or an ignored operation does not leave the idle
// state; an out-of-range write first puts out an error word. A frame tick
// reads each LED from memory and then puts out its word, LED by LED; a clear
// puts out a black word for every LED. Output backpressure stretches the
// frame, one word per rsp_tready.
// ----------------------------------------------------------------------------
module priority_led_color_frame (
   input  wire logic        clock,
   input  wire logic        reset,
   // led_index[7:0], red[15:8], green[23:16], blue[31:24], mode[39:32],
   // priority_req[40], zero fill above
   input  wire logic [47:0] req_tdata,
   // operation[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pixel_index[3:0], out_green[9:4], out_red[15:10], out_blue[21:16],
   // zero fill above
   output logic [23:0]      rsp_tdata,
   // index_error[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        csr_valid,
   output logic             csr_ready
);
   import plcf_pkg::*;

   // Input word fields.
   logic [7:0]        in_led;
   logic [CHAN_W-1:0] in_red, in_green, in_blue;
   logic [MODE_W-1:0] in_mode;
   logic              in_slot;
   op_type            in_op;
   logic              req_fire;
   logic              idx_ok;
   logic              color_nz;
   logic [LED_IDX_W-1:0] in_idx;

   assign in_led   = req_tdata[7:0];
   assign in_red   = req_tdata[15:8];
   assign in_green = req_tdata[23:16];
   assign in_blue  = req_tdata[31:24];
   assign in_mode  = req_tdata[39:32];
   assign in_slot  = req_tdata[40];
   assign in_op    = op_type'(req_tuser);
   assign req_fire = req_tvalid & req_tready;
   assign idx_ok   = (9'(in_led) < 9'(LED_COUNT));
   assign color_nz = |{in_red, in_green, in_blue};
   assign in_idx   = in_led[LED_IDX_W-1:0];

   // Configuration registers.
   logic [MODE_W-1:0] bright_code_ff, blink_code_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_code_ff <= BRIGHT_RESET;
         blink_code_ff  <= BLINK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BRIGHT: bright_code_ff <= csr_data;
            CSR_BLINK:  blink_code_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Control state.
   state_type            state_ff, state_in;
   logic [LED_IDX_W-1:0] cnt_ff;
   logic [LED_IDX_W-1:0] led_ff;
   logic                 slot_ff;
   logic [MODE_W-1:0]    mode_ff;
   logic                 parity_ff;
   logic [LED_COUNT-1:0] active_ff;
   logic [LED_COUNT-1:0] live1_ff;
   logic [SLOT_DEPTH-1:0] valid_ff;

   logic out_free;
   logic is_last;
   logic scale_done;
   logic scale_start;
   logic mem_we;
   logic load_out;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign is_last  = (cnt_ff == LED_IDX_W'(LED_COUNT - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (in_op)
                  OP_WRITE: begin
                     if (!idx_ok)       state_in = ST_ERR_OUT;
                     else if (color_nz) state_in = ST_SCALE;
                  end
                  OP_TICK:  state_in = ST_TICK_RD;
                  OP_CLEAR: state_in = ST_CLEAR_OUT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCALE: begin
            if (scale_done) state_in = ST_IDLE;
         end
         ST_TICK_RD: state_in = ST_TICK_OUT;
         ST_TICK_OUT: begin
            if (out_free) state_in = is_last ? ST_IDLE : ST_TICK_RD;
         end
         ST_CLEAR_OUT: begin
            if (out_free && is_last) state_in = ST_IDLE;
         end
         ST_ERR_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Color memory.
   slot_entry_type             mem [SLOT_DEPTH];
   slot_entry_type             rd_data_ff;
   logic                       rd_valid_ff;
   slot_entry_type             wr_data;
   logic [SLOT_ADDR_W-1:0]     wr_addr, rd_addr;
   level_vec_type              level;
   chan_vec_type               scale_chan;

   assign wr_addr = {led_ff, slot_ff};
   assign rd_addr = {cnt_ff, active_ff[cnt_ff]};
   assign wr_data = '{green: level[1], red: level[0], blue: level[2], mode: mode_ff};

   // Writes happen only while scaling; the read port is not gated, but its
   // data is used only during a tick.
   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign scale_chan = {in_blue, in_green, in_red};

   plcf_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .start       (scale_start),
      .bright_high (in_mode == bright_code_ff),
      .chan        (scale_chan),
      .done        (scale_done),
      .level       (level)
   );

   // Outputs and strobes of the sequencer.
   logic [3:0]         out_idx;
   logic [LEVEL_W-1:0] out_g, out_r, out_b;
   logic               out_last, out_err;
   logic [MODE_W-1:0]  shown_mode;
   logic               show;

   assign shown_mode = rd_valid_ff ? rd_data_ff.mode : '0;

   always_comb begin
      if (shown_mode == blink_code_ff) show = (parity_ff == cnt_ff[0]);
      else                             show = (shown_mode != '0);
   end

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      scale_start = req_fire && (in_op == OP_WRITE) && idx_ok && color_nz;
      mem_we      = (state_ff == ST_SCALE) && scale_done;
      load_out    = 1'b0;
      out_idx     = '0;
      out_g       = '0;
      out_r       = '0;
      out_b       = '0;
      out_last    = 1'b0;
      out_err     = 1'b0;
      case (state_ff)
         ST_TICK_OUT: begin
            load_out = out_free;
            out_idx  = 4'(cnt_ff);
            out_last = is_last;
            if (show && rd_valid_ff) begin
               out_g = rd_data_ff.green;
               out_r = rd_data_ff.red;
               out_b = rd_data_ff.blue;
            end
         end
         ST_CLEAR_OUT: begin
            load_out = out_free;
            out_idx  = 4'(cnt_ff);
            out_last = is_last;
         end
         ST_ERR_OUT: begin
            load_out = out_free;
            out_err  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer state and per-LED flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         parity_ff <= 1'b0;
         active_ff <= '0;
         live1_ff  <= '0;
         valid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            cnt_ff <= '0;
            case (in_op)
               OP_WRITE: begin
                  if (idx_ok && color_nz) begin
                     if (in_slot) begin
                        active_ff[in_idx] <= 1'b1;
                        live1_ff[in_idx]  <= (in_mode != '0);
                     end
                  end else if (idx_ok) begin
                     // Black empties the slot; slot 1 stays on top only if
                     // it still holds a nonzero mode.
                     valid_ff[{in_idx, in_slot}] <= 1'b0;
                     if (in_slot) begin
                        live1_ff[in_idx]  <= 1'b0;
                        active_ff[in_idx] <= 1'b0;
                     end else begin
                        active_ff[in_idx] <= live1_ff[in_idx];
                     end
                  end
               end
               OP_TICK: parity_ff <= ~parity_ff;
               OP_CLEAR: begin
                  active_ff <= '0;
                  live1_ff  <= '0;
                  valid_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
         if (mem_we) valid_ff[wr_addr] <= 1'b1;
         if (load_out && !is_last) cnt_ff <= cnt_ff + LED_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (scale_start) begin
         led_ff  <= in_idx;
         slot_ff <= in_slot;
         mode_ff <= in_mode;
      end
   end

   // Output register.
   logic               rsp_valid_ff;
   logic [3:0]         rsp_idx_ff;
   logic [LEVEL_W-1:0] rsp_g_ff, rsp_r_ff, rsp_b_ff;
   logic               rsp_last_ff, rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_idx_ff  <= out_idx;
         rsp_g_ff    <= out_g;
         rsp_r_ff    <= out_r;
         rsp_b_ff    <= out_b;
         rsp_last_ff <= out_last;
         rsp_err_ff  <= out_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_b_ff, rsp_r_ff, rsp_g_ff, rsp_idx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire

// ----- tb/sv/priority_led_color_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_led_color_frame_checker
// Watches the request, result and register channels of the LED frame block.
// It keeps its own copy of the two-slot color store and the mode registers.
// For every accepted request it queues the LED words the block must return.
// Each returned word is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module priority_led_color_frame_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   output int               mismatches,
   output int               outstanding
);
   import plcf_pkg::*;

   typedef struct packed {
      logic [3:0]         pixel;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] blue;
      logic               last;
      logic               err;
   } pixel_word_type;

   pixel_word_type     expected_pixels[$];

   logic [LEVEL_W-1:0] color_g[LED_COUNT][2];
   logic [LEVEL_W-1:0] color_r[LED_COUNT][2];
   logic [LEVEL_W-1:0] color_b[LED_COUNT][2];
   logic [MODE_W-1:0]  color_mode[LED_COUNT][2];
   logic               shown_slot[LED_COUNT];
   logic               parity;
   logic [MODE_W-1:0]  bright_code;
   logic [MODE_W-1:0]  blink_code;

   function automatic logic [LEVEL_W-1:0] scale_channel(input int unsigned value,
                                                        input int unsigned level,
                                                        input int unsigned total);
      return LEVEL_W'(value * level / total);
   endfunction

   function automatic string describe(input pixel_word_type w);
      return $sformatf("led=%0d g=%0d r=%0d b=%0d last=%0b err=%0b",
                       w.pixel, w.green, w.red, w.blue, w.last, w.err);
   endfunction

   task automatic wipe_store();
      for (int i = 0; i < LED_COUNT; i++) begin
         shown_slot[i] = 1'b0;
         for (int s = 0; s < 2; s++) begin
            color_g[i][s]    = '0;
            color_r[i][s]    = '0;
            color_b[i][s]    = '0;
            color_mode[i][s] = '0;
         end
      end
   endtask

   task automatic push_pixel(input int led, input logic [LEVEL_W-1:0] g,
                             input logic [LEVEL_W-1:0] r, input logic [LEVEL_W-1:0] b,
                             input logic err);
      pixel_word_type w;
      w.pixel = 4'(led);
      w.green = g;
      w.red   = r;
      w.blue  = b;
      w.last  = !err && (led == LED_COUNT - 1);
      w.err   = err;
      expected_pixels.push_back(w);
   endtask

   task automatic apply_request(input logic [1:0] op, input logic [47:0] data);
      logic [7:0]  led;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  mode;
      logic        pr;
      logic        s;
      logic        show;
      int unsigned total;
      int unsigned level;
      led   = data[7:0];
      r     = data[15:8];
      g     = data[23:16];
      b     = data[31:24];
      mode  = data[39:32];
      pr    = data[40];
      total = int'(r) + int'(g) + int'(b);
      case (op)
         OP_WRITE: begin
            if (led >= LED_COUNT) begin
               push_pixel(0, '0, '0, '0, 1'b1);
            end else if (total != 0) begin
               level = (mode == bright_code) ? 32'(BRIGHT_HIGH) : 32'(BRIGHT_LOW);
               if (pr) begin
                  shown_slot[led] = 1'b1;
               end
               color_g[led][pr]    = scale_channel(32'(g), level, total);
               color_r[led][pr]    = scale_channel(32'(r), level, total);
               color_b[led][pr]    = scale_channel(32'(b), level, total);
               color_mode[led][pr] = mode;
            end else begin
               // Black empties the slot; the LED falls back to the high slot
               // only if that one still carries a mode.
               color_g[led][pr]    = '0;
               color_r[led][pr]    = '0;
               color_b[led][pr]    = '0;
               color_mode[led][pr] = '0;
               shown_slot[led]     = (color_mode[led][1] != '0);
            end
         end
         OP_TICK: begin
            parity = ~parity;
            for (int i = 0; i < LED_COUNT; i++) begin
               s = shown_slot[i];
               if (color_mode[i][s] == blink_code) begin
                  show = (parity == i[0]);
               end else begin
                  show = (color_mode[i][s] != '0);
               end
               if (show) begin
                  push_pixel(i, color_g[i][s], color_r[i][s], color_b[i][s], 1'b0);
               end else begin
                  push_pixel(i, '0, '0, '0, 1'b0);
               end
            end
         end
         OP_CLEAR: begin
            wipe_store();
            for (int i = 0; i < LED_COUNT; i++) begin
               push_pixel(i, '0, '0, '0, 1'b0);
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_pixel();
      pixel_word_type got;
      pixel_word_type want;
      got.pixel = rsp_tdata[3:0];
      got.green = rsp_tdata[9:4];
      got.red   = rsp_tdata[15:10];
      got.blue  = rsp_tdata[21:16];
      got.last  = rsp_tlast;
      got.err   = rsp_tuser;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         $display("%0t: LED word arrived with none expected: got %s", $time, describe(got));
      end else begin
         want = expected_pixels.pop_front();
         if (got.pixel !== want.pixel || got.green !== want.green ||
             got.red !== want.red || got.blue !== want.blue ||
             got.last !== want.last || got.err !== want.err) begin
            mismatches++;
            $display("%0t: LED word differs: expected %s, got %s",
                     $time, describe(want), describe(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bright_code = BRIGHT_RESET;
         blink_code  = BLINK_RESET;
         parity      = 1'b0;
         wipe_store();
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BRIGHT) begin
               bright_code = csr_data;
            end else if (csr_index == CSR_BLINK) begin
               blink_code = csr_data;
            end
         end
         // Results of this edge cannot come from a request accepted at it.
         if (rsp_tvalid && rsp_tready) begin
            check_pixel();
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata);
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

// ----- tb/sv/priority_led_color_frame_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_led_color_frame_tb
// Stimulus and verdict for the priority LED color frame block.
// A directed run covers the field extremes, every operation and the corner
// cases of slot priority, blinking and bad indexes. Random phases then mix
// writes, ticks, clears and unused operations under several mode settings and handshake idling,
// one of them with a long output stall. The checker does all comparison.
// ----------------------------------------------------------------------------
module priority_led_color_frame_tb;
   import plcf_pkg::*;

   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         SETTLE_CYCLES = 2 * LED_COUNT + 16;
   localparam int         HOLD_CYCLES   = 300;
   localparam int         PHASE_ITEMS   = 80;

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  csr_index;
   logic [7:0]  csr_data;
   logic        csr_valid;
   logic        csr_ready;

   int          mismatches;
   int          outstanding;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        long_hold = 1'b0;
   int          hold_count = 0;
   logic [7:0]  bright_code = BRIGHT_RESET;
   logic [7:0]  blink_code = BLINK_RESET;

   priority_led_color_frame dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   priority_led_color_frame_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d LED words still expected", outstanding);
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off counted here.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && hold_count < HOLD_CYCLES) begin
            rsp_tready = 1'b0;
            hold_count++;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [7:0] led,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] mode, input logic pr);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tuser  = op;
      req_tdata  = {7'd0, pr, mode, b, g, r, led};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Waits until every expected word is back, then settles so that a write still being scaled can finish.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_word();
      int unsigned pick;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  mode;
      pick = $urandom_range(99);
      r    = 8'($urandom);
      g    = 8'($urandom);
      b    = 8'($urandom);
      case ($urandom_range(3))
         0:       mode = '0;
         1:       mode = bright_code;
         2:       mode = blink_code;
         default: mode = 8'($urandom);
      endcase
      if ($urandom_range(7) == 0) begin
         r = '0;
         g = '0;
         b = '0;
      end else if ($urandom_range(7) == 0) begin
         r = 8'($urandom_range(2));
         g = 8'($urandom_range(2));
         b = 8'($urandom_range(2));
      end
      if (pick < 14) begin
         send_word(OP_TICK, 8'($urandom), r, g, b, mode, 1'($urandom_range(1)));
      end else if (pick < 17) begin
         send_word(OP_CLEAR, 8'($urandom), r, g, b, mode, 1'($urandom_range(1)));
      end else if (pick < 19) begin
         send_word(OP_UNUSED, 8'($urandom), r, g, b, mode, 1'($urandom_range(1)));
      end else if (pick < 25) begin
         send_word(OP_WRITE, 8'($urandom_range(255, LED_COUNT)), r, g, b, mode,
                   1'($urandom_range(1)));
      end else begin
         send_word(OP_WRITE, 8'($urandom_range(LED_COUNT - 1)), r, g, b, mode,
                   1'($urandom_range(1)));
      end
   endtask

   task automatic run_phase(input logic [7:0] bright, input logic [7:0] blink,
                            input int send_pct, input int recv_pct, input logic squeeze);
      drain();
      csr_write(CSR_BRIGHT, bright);
      csr_write(CSR_BLINK, blink);
      bright_code    = bright;
      blink_code     = blink;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (squeeze) begin
         // The first frame stalls behind the held output and the block stops accepting requests.
         long_hold = 1'b1;
         repeat (3) send_word(OP_TICK, '0, '0, '0, '0, '0, 1'b0);
      end
      repeat (PHASE_ITEMS) send_random_word();
   endtask

   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = '0;
      req_tvalid = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      csr_valid  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset mode codes and no idling.
      send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_word(OP_WRITE, 8'd0, 8'd255, 8'd255, 8'd255, BRIGHT_RESET, 1'b0);
      send_word(OP_WRITE, 8'd1, 8'd255, 8'd0, 8'd0, BLINK_RESET, 1'b1);
      send_word(OP_WRITE, 8'd2, 8'd0, 8'd1, 8'd0, 8'd5, 1'b0);
      // A color stored with mode zero stays dark.
      send_word(OP_WRITE, 8'd3, 8'd10, 8'd20, 8'd30, 8'd0, 1'b0);
      // Clearing the high slot drops the LED back to its low slot.
      send_word(OP_WRITE, 8'd4, 8'd1, 8'd2, 8'd3, 8'd9, 1'b1);
      send_word(OP_WRITE, 8'd4, 8'd200, 8'd100, 8'd50, BRIGHT_RESET, 1'b0);
      send_word(OP_WRITE, 8'd4, 8'd0, 8'd0, 8'd0, 8'd9, 1'b1);
      // Clearing the low slot keeps a live high slot in front.
      send_word(OP_WRITE, 8'd5, 8'd7, 8'd7, 8'd7, 8'd3, 1'b1);
      send_word(OP_WRITE, 8'd5, 8'd0, 8'd0, 8'd0, 8'd3, 1'b0);
      send_word(OP_WRITE, 8'(LED_COUNT), 8'd1, 8'd1, 8'd1, 8'd1, 1'b0);
      send_word(OP_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_word(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_word(OP_WRITE, 8'(LED_COUNT - 1), 8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
      send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_word(OP_TICK, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_word(OP_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      send_word(OP_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);

      run_phase(BRIGHT_RESET, BLINK_RESET, 0, 0, 1'b0);
      run_phase(8'd255, 8'd0, 76, 0, 1'b0);
      run_phase(8'd0, 8'd255, 0, 76, 1'b0);
      run_phase(8'd7, 8'd7, 24, 24, 1'b0);
      run_phase(8'd200, 8'd3, 0, 0, 1'b1);
      run_phase(8'd1, 8'd2, 76, 76, 1'b0);
      drain();

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/plcf_pkg.sv
rtl/plcf_scale.sv
rtl/priority_led_color_frame.sv
tb/sv/priority_led_color_frame_checker.sv
tb/sv/priority_led_color_frame_tb.sv
